// File: rtl/core/cwfc_pkg.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator: shared types and constants
// Field positions of the configuration words, the status codes, the widths
// of the scaled operands and the entry that the queue carries.
// ----------------------------------------------------------------------------
package cwfc_pkg;

  // Width of the reference frequency register.
  localparam int REF_W = 10;

  // Fixed-point scale of the fractional fields (thousandths).
  localparam int SCALE = 1000;

  // Widths of the scaled operands. The common factor of 1000 is removed
  // from numerator and denominator, so the quotient is unchanged:
  //   term  = field * 1000 + frac    <= 256023          (18 bits)
  //   num   = ref * mul_term         <= 261911529       (28 bits)
  //   den   = div0 * div_term        <= 65285865        (26 bits)
  localparam int TERM_W = 18;
  localparam int NUM_W  = 28;
  localparam int DEN_W  = 26;

  // Result frequency width.
  localparam int FREQ_W = 16;

  // Configuration word 0 layout.
  localparam int W0_DIV_LSB   = 0;
  localparam int W0_MUL_LSB   = 8;
  localparam int W0_FRAC_LSB  = 16;
  localparam int W0_FRAC_EN   = 26;

  // Configuration word 2 layout.
  localparam int W2_DIV_LSB   = 0;
  localparam int W2_FRAC_LSB  = 8;
  localparam int W2_FRAC_EN   = 18;

  localparam int FIELD_W = 8;
  localparam int FRAC_W  = 10;

  // Reference frequency after reset, in MHz.
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(100);

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNLOCKED = 2'd1,
    STATUS_ZERO_DIV = 2'd2
  } status_t;

  // One classified item, as held in the queue between front and back.
  typedef struct packed {
    status_t             status;
    logic [TERM_W-1:0]   mul_term;
    logic [FIELD_W-1:0]  div0;
    logic [TERM_W-1:0]   div_term;
  } entry_t;

endpackage

// File: rtl/core/cwfc_front.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator: front end
// Unpacks the lock flag and both configuration words, forms the scaled
// multiplier and divider terms and classifies the item by status.
// ----------------------------------------------------------------------------
module cwfc_front
  import cwfc_pkg::*;
(
  input  logic         locked,
  input  logic [31:0]  config_word0,
  input  logic [31:0]  config_word2,
  output entry_t       entry
);

  logic [FIELD_W-1:0] div0;
  logic [FIELD_W-1:0] mul;
  logic [FIELD_W-1:0] div1;
  logic [FRAC_W-1:0]  mfrac;
  logic [FRAC_W-1:0]  dfrac;
  logic               zero_div;

  // Field extraction; a fraction counts only when its enable bit is set.
  always_comb begin
    div0  = config_word0[W0_DIV_LSB +: FIELD_W];
    mul   = config_word0[W0_MUL_LSB +: FIELD_W];
    mfrac = config_word0[W0_FRAC_EN] ? config_word0[W0_FRAC_LSB +: FRAC_W] : '0;
    div1  = config_word2[W2_DIV_LSB +: FIELD_W];
    dfrac = config_word2[W2_FRAC_EN] ? config_word2[W2_FRAC_LSB +: FRAC_W] : '0;
  end

  // The divisor is zero when the input divider is zero, or when the whole
  // output divider term is zero.
  assign zero_div = (div0 == '0) || ((div1 == '0) && (dfrac == '0));

  // Scaled terms and classification.
  always_comb begin
    entry.mul_term = TERM_W'(mul) * TERM_W'(SCALE) + TERM_W'(mfrac);
    entry.div_term = TERM_W'(div1) * TERM_W'(SCALE) + TERM_W'(dfrac);
    entry.div0     = div0;
    if (!locked) begin
      entry.status = STATUS_UNLOCKED;
    end else if (zero_div) begin
      entry.status = STATUS_ZERO_DIV;
    end else begin
      entry.status = STATUS_OK;
    end
  end

endmodule

// File: rtl/core/cwfc_queue.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator: item queue
// A short first-in first-out queue of classified items that decouples the
// front end from the divider pipeline.
// ----------------------------------------------------------------------------
module cwfc_queue
  import cwfc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  // Storage writes carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/cwfc_back.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator: back end
// Forms numerator and denominator with one multiply stage, then divides in
// a restoring pipeline of one quotient bit per stage, and holds the result
// in an output register. The whole pipeline advances when that register is
// empty or being taken.
// ----------------------------------------------------------------------------
module cwfc_back
  import cwfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [REF_W-1:0]  ref_freq_mhz,
  input  entry_t            head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] freq_mhz,
  output status_t           result_status
);

  localparam int STAGES = NUM_W;

  logic advance;

  // Stage 0 is the multiply stage; stages 1..STAGES each resolve one bit.
  logic               valid  [STAGES+1];
  status_t            status [STAGES+1];
  logic [NUM_W-1:0]   nq     [STAGES+1];
  logic [DEN_W-1:0]   rem    [STAGES+1];
  logic [DEN_W-1:0]   den    [STAGES+1];

  logic [NUM_W-1:0]   nq_next  [STAGES+1];
  logic [DEN_W-1:0]   rem_next [STAGES+1];

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  // One restoring step per stage: bring down the next dividend bit,
  // subtract the divisor if it fits, and shift the quotient bit in.
  always_comb begin
    logic [DEN_W:0] trial;
    logic           fits;
    nq_next[0]  = '0;
    rem_next[0] = '0;
    for (int k = 1; k <= STAGES; k++) begin
      trial       = {rem[k-1], nq[k-1][NUM_W-1]};
      fits        = (trial >= {1'b0, den[k-1]});
      rem_next[k] = fits ? DEN_W'(trial - {1'b0, den[k-1]}) : DEN_W'(trial);
      nq_next[k]  = {nq[k-1][NUM_W-2:0], fits};
    end
  end

  // Multiply stage and divider payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      status[0] <= head.status;
      nq[0]     <= NUM_W'(ref_freq_mhz) * NUM_W'(head.mul_term);
      den[0]    <= DEN_W'(head.div0) * DEN_W'(head.div_term);
      rem[0]    <= '0;
      for (int k = 1; k <= STAGES; k++) begin
        status[k] <= status[k-1];
        den[k]    <= den[k-1];
        nq[k]     <= nq_next[k];
        rem[k]    <= rem_next[k];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STAGES; k++) begin
        valid[k] <= 1'b0;
      end
    end else if (advance) begin
      valid[0] <= !empty;
      for (int k = 1; k <= STAGES; k++) begin
        valid[k] <= valid[k-1];
      end
    end
  end

  // Output register; a failed item reports a frequency of zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= valid[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_status <= status[STAGES];
      freq_mhz      <= (status[STAGES] == STATUS_OK) ? nq[STAGES][FREQ_W-1:0] : '0;
    end
  end

endmodule

// File: rtl/core/clock_wizard_frequency_calc_unit.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator
// Path: an input transfer is written into the queue at the transfer edge and,
//   when the queue is empty, passes the multiply stage, 28 divide stages and
//   the output register before the result appears on m_tdata.
// Throughput: one item per cycle unless stalled, as the divider is pipelined.
// Reset: rst clears the queue, the pipeline valid bits and the output, and
//   sets the reference frequency to 100 MHz.
// ----------------------------------------------------------------------------
module clock_wizard_frequency_calc_unit
  import cwfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration: reference frequency in MHz
  input  logic              cfg_we,
  input  logic [REF_W-1:0]  cfg_wdata,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // [0] locked, [32:1] config_word0, [64:33] config_word2, [71:65] zero
  input  logic [71:0]       s_tdata,
  // Output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // [15:0] freq_mhz, [17:16] result_status, [23:18] zero
  output logic [23:0]       m_tdata
);

  logic [REF_W-1:0]  ref_freq_mhz;
  entry_t            front_entry;
  entry_t            head;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  logic [FREQ_W-1:0] freq_mhz;
  status_t           result_status;

  // Reference frequency register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq_mhz <= REF_RESET;
    end else if (cfg_we) begin
      ref_freq_mhz <= cfg_wdata;
    end
  end

  // An input transfer goes straight into the queue.
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  cwfc_front u_front (
    .locked       (s_tdata[0]),
    .config_word0 (s_tdata[32:1]),
    .config_word2 (s_tdata[64:33]),
    .entry        (front_entry)
  );

  cwfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  cwfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ref_freq_mhz  (ref_freq_mhz),
    .head          (head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .freq_mhz      (freq_mhz),
    .result_status (result_status)
  );

  // Output packing.
  assign m_tdata = {6'b0, result_status, freq_mhz};

endmodule

// File: rtl/core/cwfc_checker.sv
// ----------------------------------------------------------------------------
// Clock wizard frequency calculator: port checker
// Watches the output stream of the top level and checks reset, holding
// under stall and the consistency of status and frequency.
// ----------------------------------------------------------------------------
module cwfc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata
);

  // No result is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The status field never carries the unused code.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:16] != 2'd3)
    else $error("invalid status code");

  // A failed item reports a frequency of zero and the padding stays clear.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] != 2'd0 |-> m_tdata[15:0] == 16'd0 && m_tdata[23:18] == 6'd0)
    else $error("failed item with nonzero frequency");

endmodule

bind clock_wizard_frequency_calc_unit cwfc_checker u_cwfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
